// ----- rtl/core/llka_pkg.sv -----
// ----------------------------------------------------------------------------
// llka_pkg
// Shared types, register codes and fp32 helper functions for the
// cross-entropy Kahan accumulator.
// ----------------------------------------------------------------------------
package llka_pkg;

  localparam int unsigned MaxLabelsDefault = 65536;
  localparam int unsigned FifoDepth        = 4;
  localparam int unsigned FifoPtrW         = $clog2(FifoDepth);
  localparam int unsigned FifoCntW         = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    REG_ALPHA        = 2'd0,
    REG_LABEL_COUNT  = 2'd1,
    REG_INPUT_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP64 = 2'd1,
    FMT_BF16 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } fp_op_e;

  typedef enum logic [2:0] {
    PH_ISSUE = 3'b001,
    PH_NORM  = 3'b010,
    PH_ROUND = 3'b100
  } phase_e;

  typedef struct packed {
    logic [63:0] score_value;
    logic [63:0] logsumexp_value;
    logic [15:0] label;
    logic        last_column;
    logic        restart_total;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_bits;
    logic        label_missing;
  } out_item_t;

  typedef struct packed {
    logic [31:0] alpha_bits;
    logic [16:0] label_count;
    logic [1:0]  input_format;
  } cfg_t;

  // work handed from the front end to the back end
  typedef struct packed {
    logic [31:0] lse;
    logic [31:0] nscore;
    logic        matched;
    logic        final_col;
    logic        restart;
    logic        label_missing;
  } job_t;

  typedef struct packed {
    logic busy;
    logic result_load;
  } back_stat_t;

  // operation after operand alignment / product
  typedef struct packed {
    logic               special;
    logic [31:0]        spec_bits;
    logic               sign;
    logic               is_mul;
    logic signed [10:0] exp;
    logic [47:0]        wide;
  } fp_mid_t;

  // normalised mantissa with guard, round and sticky bits
  typedef struct packed {
    logic               special;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [10:0] exp;
    logic [26:0]        man;
  } fp_norm_t;

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

  function automatic logic is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  function automatic logic [31:0] narrow_fp64(input logic [63:0] raw);
    logic               sgn;
    logic [10:0]        e64;
    logic [51:0]        fr;
    logic signed [12:0] e32;
    logic [11:0]        s;
    logic [63:0]        x;
    logic [63:0]        q;
    logic [63:0]        half;
    logic               g;
    logic               st;
    logic               inc;
    logic [31:0]        r;
    sgn = raw[63];
    e64 = raw[62:52];
    fr  = raw[51:0];
    r   = {sgn, 31'd0};
    e32 = $signed({2'b00, e64}) - 13'sd896;
    if (e64 == 11'h7FF) begin
      if (fr != 52'd0) r = {sgn, 8'hFF, 1'b1, fr[50:29]};
      else             r = {sgn, 8'hFF, 23'd0};
    end else if (e64 == 11'd0) begin
      r = {sgn, 31'd0};
    end else if (e32 >= 13'sd255) begin
      r = {sgn, 8'hFF, 23'd0};
    end else if (e32 >= 13'sd1) begin
      g   = fr[28];
      st  = |fr[27:0];
      inc = g & (st | fr[29]);
      r   = {sgn, 31'({e32[7:0], fr[51:29]}) + 31'(inc)};
    end else begin
      s = 12'd926 - {1'b0, e64};
      x = {11'd0, 1'b1, fr};
      if (s > 12'd63) begin
        r = {sgn, 31'd0};
      end else begin
        q    = x >> s[5:0];
        half = 64'd1 << (s[5:0] - 6'd1);
        g    = |(x & half);
        st   = |(x & (half - 64'd1));
        inc  = g & (st | q[0]);
        r    = {sgn, q[30:0] + 31'(inc)};
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] to_fp32(input logic [63:0] raw, input logic [1:0] fmt);
    logic [31:0] r;
    unique case (fmt)
      FMT_FP64: r = narrow_fp64(raw);
      FMT_BF16: r = {raw[15:0], 16'd0};
      default:  r = raw[31:0];
    endcase
    return r;
  endfunction

  function automatic fp_mid_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t     m;
    logic        swap;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] al;
    logic [27:0] sum;
    m = '0;
    if (is_nan(a)) begin
      m.special = 1'b1; m.spec_bits = a | 32'h0040_0000;
    end else if (is_nan(b)) begin
      m.special = 1'b1; m.spec_bits = b | 32'h0040_0000;
    end else if (is_inf(a)) begin
      m.special = 1'b1;
      m.spec_bits = (is_inf(b) && (a[31] != b[31])) ? DefaultNan : a;
    end else if (is_inf(b)) begin
      m.special = 1'b1; m.spec_bits = b;
    end else begin
      swap = b[30:0] > a[30:0];
      x    = swap ? b : a;
      y    = swap ? a : b;
      ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d    = ex - ey;
      mx   = {x[30:23] != 8'd0, x[22:0], 3'b000};
      my   = {y[30:23] != 8'd0, y[22:0], 3'b000};
      if (d > 8'd26) begin
        al = {26'd0, |my};
      end else begin
        al = (my >> d[4:0]) | 27'(|(my & ((27'd1 << d[4:0]) - 27'd1)));
      end
      if (x[31] ^ y[31]) sum = {1'b0, mx} - {1'b0, al};
      else               sum = {1'b0, mx} + {1'b0, al};
      if (sum == 28'd0) begin
        m.special = 1'b1; m.spec_bits = {x[31] & y[31], 31'd0};
      end else begin
        m.sign = x[31];
        m.exp  = $signed({3'b000, ex});
        m.wide = {20'd0, sum};
      end
    end
    return m;
  endfunction

  function automatic fp_mid_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t    m;
    logic       sgn;
    logic [7:0] ea;
    logic [7:0] eb;
    m   = '0;
    sgn = a[31] ^ b[31];
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    if (is_nan(a)) begin
      m.special = 1'b1; m.spec_bits = a | 32'h0040_0000;
    end else if (is_nan(b)) begin
      m.special = 1'b1; m.spec_bits = b | 32'h0040_0000;
    end else if (is_inf(a) || is_inf(b)) begin
      m.special = 1'b1;
      m.spec_bits = ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) ? DefaultNan
                                                               : {sgn, 8'hFF, 23'd0};
    end else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
      m.special = 1'b1; m.spec_bits = {sgn, 31'd0};
    end else begin
      m.sign   = sgn;
      m.is_mul = 1'b1;
      m.exp    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
      m.wide   = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
    end
    return m;
  endfunction

  function automatic fp_norm_t fp_norm(input fp_mid_t m);
    fp_norm_t           n;
    logic [4:0]         lz;
    logic [5:0]         lzw;
    logic signed [10:0] lim;
    logic signed [10:0] sh;
    logic signed [10:0] en;
    logic signed [10:0] rsh;
    logic [47:0]        p2;
    logic [26:0]        mm;
    n.special   = m.special;
    n.spec_bits = m.spec_bits;
    n.sign      = m.sign;
    n.exp       = m.exp;
    n.man       = '0;
    lz  = 5'd27;
    lzw = 6'd48;
    for (int i = 0; i < 27; i++) if (m.wide[i]) lz = 5'(26 - i);
    for (int i = 0; i < 48; i++) if (m.wide[i]) lzw = 6'(47 - i);
    if (!m.special) begin
      if (!m.is_mul) begin
        if (m.wide[27]) begin
          n.man = {m.wide[27:2], m.wide[1] | m.wide[0]};
          n.exp = m.exp + 11'sd1;
        end else begin
          lim   = m.exp - 11'sd1;
          sh    = ($signed({6'd0, lz}) < lim) ? $signed({6'd0, lz}) : lim;
          n.man = m.wide[26:0] << sh[4:0];
          n.exp = m.exp - sh;
        end
      end else begin
        p2 = m.wide << lzw;
        mm = {p2[47:22], |p2[21:0]};
        en = m.exp + 11'sd1 - $signed({5'd0, lzw});
        if (en >= 11'sd1) begin
          n.man = mm;
          n.exp = en;
        end else begin
          rsh = 11'sd1 - en;
          if (rsh > 11'sd26) n.man = {26'd0, |mm};
          else n.man = (mm >> rsh[4:0]) | 27'(|(mm & ((27'd1 << rsh[4:0]) - 27'd1)));
          n.exp = 11'sd1;
        end
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] fp_round(input fp_norm_t n);
    logic               inc;
    logic [24:0]        mant;
    logic signed [10:0] ef;
    logic [22:0]        fr;
    logic [31:0]        r;
    inc  = n.man[2] & ((|n.man[1:0]) | n.man[3]);
    mant = {1'b0, n.man[26:3]} + 25'(inc);
    if (mant[24]) begin
      ef = n.exp + 11'sd1;
      fr = 23'd0;
    end else begin
      ef = mant[23] ? n.exp : 11'sd0;
      fr = mant[22:0];
    end
    if (n.special)           r = n.spec_bits;
    else if (ef >= 11'sd255) r = {n.sign, 8'hFF, 23'd0};
    else                     r = {n.sign, ef[7:0], fr};
    return r;
  endfunction

endpackage

// ----- rtl/core/llka_front.sv -----
// ----------------------------------------------------------------------------
// llka_front
// Row tracking, label match, input decoding and job creation.
// ----------------------------------------------------------------------------
module llka_front #(
  parameter int unsigned MAX_LABELS = llka_pkg::MaxLabelsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  llka_pkg::in_item_t in_data_i,
  input  llka_pkg::cfg_t     cfg_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output llka_pkg::job_t     job_o
);
  import llka_pkg::*;

  localparam int unsigned LimitRows = (MAX_LABELS < 65536) ? MAX_LABELS : 65536;
  localparam int unsigned RowW      = $clog2(LimitRows);

  logic [RowW-1:0] row_q, row_d;
  logic            col_match_q, col_match_d;
  logic            err_q, err_d;
  logic [16:0]     rows;
  logic            accept, match, col_end, closing, col_err;
  logic [31:0]     score32;

  always_comb begin
    if (cfg_i.label_count == 17'd0)                 rows = 17'd1;
    else if (cfg_i.label_count > 17'(LimitRows))    rows = 17'(LimitRows);
    else                                            rows = cfg_i.label_count;
  end

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign match      = 17'(row_q) == {1'b0, in_data_i.label};
  assign col_end    = (17'(row_q) + 17'd1) >= rows;
  assign closing    = col_end && in_data_i.last_column;
  assign col_err    = col_end && !(col_match_q || match);
  assign score32    = to_fp32(in_data_i.score_value, cfg_i.input_format);

  assign push_o              = accept && (match || closing || in_data_i.restart_total);
  assign job_o.lse           = to_fp32(in_data_i.logsumexp_value, cfg_i.input_format);
  assign job_o.nscore        = {~score32[31], score32[30:0]};
  assign job_o.matched       = match;
  assign job_o.final_col     = closing;
  assign job_o.restart       = in_data_i.restart_total;
  assign job_o.label_missing = err_q | col_err;

  always_comb begin
    row_d       = row_q;
    col_match_d = col_match_q;
    err_d       = err_q;
    if (accept) begin
      row_d       = col_end ? '0 : row_q + RowW'(1);
      col_match_d = col_end ? 1'b0 : (col_match_q | match);
      err_d       = closing ? 1'b0 : (err_q | col_err);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_match_q <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_match_q <= col_match_d;
      err_q       <= err_d;
    end
  end

endmodule

// ----- rtl/core/llka_fifo.sv -----
// ----------------------------------------------------------------------------
// llka_fifo
// Short job queue decoupling the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module llka_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  llka_pkg::job_t                  data_i,
  output logic                            full_o,
  output logic                            valid_o,
  output llka_pkg::job_t                  data_o,
  input  logic                            pop_i,
  output logic [llka_pkg::FifoCntW-1:0]   count_o
);
  import llka_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = cnt_q == FifoCntW'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + FifoPtrW'(1);
      if (pop_i)  rd_q <= (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + FifoPtrW'(1);
      cnt_q <= cnt_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
    end
  end

endmodule

// ----- rtl/core/llka_back.sv -----
// ----------------------------------------------------------------------------
// llka_back
// Kahan steps and final scaling on one shared fp32 add/multiply datapath.
// ----------------------------------------------------------------------------
module llka_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          alpha_i,
  input  logic                 job_valid_i,
  input  llka_pkg::job_t       job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output llka_pkg::out_item_t  out_data_o,
  output llka_pkg::back_stat_t stat_o
);
  import llka_pkg::*;

  localparam logic [3:0] StepLseEnd   = 4'd7;
  localparam logic [3:0] StepFinal    = 4'd8;
  localparam logic [3:0] StepLast     = 4'd11;

  logic        busy_q;
  phase_e      phase_q;
  logic [3:0]  step_q;
  job_t        job_q;
  logic [31:0] sum_q, comp_q, tot_q, y_q, t_q, d_q;
  fp_mid_t     mid_q;
  fp_norm_t    norm_q;
  out_item_t   out_q;
  logic        out_valid_q;

  fp_op_e      op;
  logic [31:0] opa, opb, opb_neg, res;
  logic        round_go, result_load, step_done;

  // micro-program: two Kahan updates on match, scale and add at batch end
  always_comb begin
    unique case (step_q)
      4'd0:    begin op = OP_SUB; opa = job_q.lse;    opb = comp_q; end
      4'd4:    begin op = OP_SUB; opa = job_q.nscore; opb = comp_q; end
      4'd1,
      4'd5:    begin op = OP_ADD; opa = sum_q;        opb = y_q;    end
      4'd2,
      4'd6:    begin op = OP_SUB; opa = t_q;          opb = sum_q;  end
      4'd3,
      4'd7:    begin op = OP_SUB; opa = d_q;          opb = y_q;    end
      4'd8:    begin op = OP_MUL; opa = alpha_i;      opb = comp_q; end
      4'd9:    begin op = OP_MUL; opa = alpha_i;      opb = sum_q;  end
      4'd10:   begin op = OP_SUB; opa = tot_q;        opb = y_q;    end
      default: begin op = OP_ADD; opa = d_q;          opb = t_q;    end
    endcase
  end

  assign opb_neg = is_nan(opb) ? opb : {~opb[31], opb[30:0]};
  assign res     = fp_round(norm_q);

  assign pop_o       = !busy_q && job_valid_i;
  assign round_go    = busy_q && (phase_q == PH_ROUND) &&
                       !((step_q == StepLast) && out_valid_q && !out_ready_i);
  assign step_done   = round_go && ((step_q == StepLast) ||
                       ((step_q == StepLseEnd) && !job_q.final_col));
  assign result_load = round_go && (step_q == StepLast);

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign stat_o.busy        = busy_q;
  assign stat_o.result_load = result_load;

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (busy_q && (phase_q == PH_ISSUE)) begin
      mid_q <= (op == OP_MUL) ? fp_mul_pre(opa, opb)
                              : fp_add_pre(opa, (op == OP_SUB) ? opb_neg : opb);
    end
    if (busy_q && (phase_q == PH_NORM)) norm_q <= fp_norm(mid_q);
    if (round_go) begin
      unique case (step_q)
        4'd0, 4'd4, 4'd8: y_q <= res;
        4'd1, 4'd5, 4'd9: t_q <= res;
        4'd2, 4'd6, 4'd10: d_q <= res;
        default: ;
      endcase
    end
    if (result_load) out_q <= '{total_bits: res, label_missing: job_q.label_missing};
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_ISSUE;
      step_q      <= '0;
      sum_q       <= '0;
      comp_q      <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !result_load) out_valid_q <= 1'b0;
      if (pop_o) begin
        if (job_i.restart) tot_q <= '0;
        busy_q  <= job_i.matched || job_i.final_col;
        step_q  <= job_i.matched ? 4'd0 : StepFinal;
        phase_q <= PH_ISSUE;
      end else if (busy_q) begin
        unique case (phase_q)
          PH_ISSUE: phase_q <= PH_NORM;
          PH_NORM:  phase_q <= PH_ROUND;
          PH_ROUND: begin
            if (round_go) begin
              phase_q <= PH_ISSUE;
              step_q  <= step_q + 4'd1;
              if ((step_q == 4'd3) || (step_q == StepLseEnd)) begin
                comp_q <= res;
                sum_q  <= t_q;
              end
              if (step_q == StepLast) begin
                tot_q       <= res;
                sum_q       <= '0;
                comp_q      <= '0;
                out_valid_q <= 1'b1;
              end
              if (step_done) busy_q <= 1'b0;
            end
          end
          default: phase_q <= PH_ISSUE;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/label_loss_kahan_accumulator.sv -----
// ----------------------------------------------------------------------------
// label_loss_kahan_accumulator
// Cross-entropy total with fp32 Kahan summation over a streamed score matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one score element per
//   transfer, column by column, with the column's logsumexp and label.
//   Output channel (out_valid_o/out_ready_i/out_data_o): one transfer per
//   batch, after the final element of a column marked last_column.
//   Config channel (cfg_valid_i/cfg_ready_o): always ready; write only while
//   idle. Registers: alpha_bits, label_count, input_format.
// Throughput: an element that is neither the labelled row, a restart nor a
//   batch end never enters the back end. A labelled element occupies the
//   shared fp32 datapath for 8 operations, each through issue, normalise
//   and round, after its job is fetched; a batch end adds 4 operations.
//   The 4-entry job queue absorbs bursts, so one element per cycle is
//   accepted while the queue is not full.
// Result: out_valid_o comes from a register set when the closing add is
//   rounded, after any queued work ahead of the batch end.
// Reset: clears row counter, Kahan sum/compensation, running total, error
//   flag, queue and output; registers return to alpha 1.0, 65536 rows, fp32.
// Stall: a held output stalls the back end at its last rounding; the queue
//   then fills and in_ready_o drops.
// ----------------------------------------------------------------------------
module label_loss_kahan_accumulator #(
  parameter int unsigned MAX_LABELS = llka_pkg::MaxLabelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  llka_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output llka_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import llka_pkg::*;

  cfg_t                cfg_q;
  logic                push, fifo_full, fifo_valid, pop;
  job_t                job_in, job_out;
  logic [FifoCntW-1:0] fifo_count;
  back_stat_t          bstat;

  // config registers: take any write, ignore unknown indexes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_bits   <= 32'h3F80_0000;
      cfg_q.label_count  <= 17'h1_0000;
      cfg_q.input_format <= FMT_FP32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ALPHA:        cfg_q.alpha_bits   <= cfg_data_i;
        REG_LABEL_COUNT:  cfg_q.label_count  <= cfg_data_i[16:0];
        REG_INPUT_FORMAT: cfg_q.input_format <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // front end: count rows, match the label, decode, queue work
  llka_front #(
    .MAX_LABELS(MAX_LABELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  llka_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (job_out),
    .pop_i   (pop),
    .count_o (fifo_count)
  );

  // back end: Kahan arithmetic and final result register
  llka_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (cfg_q.alpha_bits),
    .job_valid_i (fifo_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (bstat)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= FifoCntW'(FifoDepth))
    else $error("job queue count beyond depth");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.result_load |-> bstat.busy)
    else $error("result loaded while back end idle");

  a_rise_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bstat.result_load))
    else $error("output valid without a result load");

endmodule
